>>> design/bgsp_pkg.sv
// Shared types, field widths and grid-mask helpers for the grid shortest-path block.
// Used by every module in this folder; it depends on nothing else.
`default_nettype none

package bgsp_pkg;

    localparam int MAP_W  = 64;
    localparam int CELL_W = 6;

    typedef struct packed {
        logic [MAP_W-1:0]  obstacle_map;
        logic [CELL_W-1:0] source_cell;
        logic [CELL_W-1:0] target_cell;
    } req_t;

    typedef struct packed {
        logic [MAP_W-1:0]  path_map;
        logic              reached;
        logic [CELL_W-1:0] path_length;
    } rsp_t;

    // Class of an item, decided in the front part.
    typedef enum logic [1:0] {
        JOB_SAME,
        JOB_BLOCKED,
        JOB_SEARCH
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [MAP_W-1:0]  obstacle_map;
        logic [CELL_W-1:0] source_cell;
        logic [CELL_W-1:0] target_cell;
    } job_t;

    // Cells that lie on a grid of the given side; all higher bits are off-grid.
    function automatic logic [MAP_W-1:0] grid_cells(input int side);
        int n;
        n = side * side;
        if (n >= MAP_W)
        begin
            return '1;
        end
        return (64'd1 << n) - 64'd1;
    endfunction

    // One bit for the first cell of each row.
    function automatic logic [MAP_W-1:0] left_column(input int side);
        logic [MAP_W-1:0] m;
        int               y;
        m = '0;
        for (y = 0; y < side; y++)
        begin
            m = m | (64'd1 << (y * side));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/bitboard_grid_shortest_path.sv
// Top level of the grid shortest-path block: front part, two-entry job queue and back part.
// It depends on bgsp_pkg, bgsp_front, bgsp_queue and bgsp_back. Each request item carries an
// obstacle bitmap, a source and a target cell. The response gives the intermediate cells of a
// shortest path, a reached flag and the path length. The front part takes a request item in
// any cycle in which the queue has room. Items whose source equals the target, or whose target
// is blocked or off the grid, go from idle straight to the done state in the back part. A search
// item grows at most MAX_WAVES waves. The back part grows one wave per cycle into a wave
// memory with one write and one read port, then reads that memory back, one earlier wave per
// cycle, to trace the path when the target was reached.
// The response sits in an output register, so the back part can start the next queued item
// while the last response still waits to be taken.
`default_nettype none

module bitboard_grid_shortest_path #(
    parameter int GRID_SIDE = 8,
    parameter int MAX_WAVES = 64
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             req_valid,
    output logic            req_stall,
    input  bgsp_pkg::req_t  req,
    output logic            rsp_valid,
    input  wire             rsp_stall,
    output bgsp_pkg::rsp_t  rsp
);

    localparam logic [bgsp_pkg::MAP_W-1:0] GRID_MASK = bgsp_pkg::grid_cells(GRID_SIDE);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    bgsp_pkg::job_t  q_job;
    bgsp_pkg::job_t  q_head;

    bgsp_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_push    (q_push),
        .q_job     (q_job),
        .q_full    (q_full)
    );

    bgsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    bgsp_back #(
        .GRID_SIDE (GRID_SIDE),
        .MAX_WAVES (MAX_WAVES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    a_unreached_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.reached |-> rsp.path_map == '0 && rsp.path_length == '0)
        else $error("Unreached response carries path cells.");

    a_length_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> int'(rsp.path_length) == $countones(rsp.path_map))
        else $error("Path length does not match the number of path cells.");

    a_path_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.path_map & ~GRID_MASK) == '0)
        else $error("Path contains an off-grid cell.");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("Job pushed into a full queue.");

endmodule

`default_nettype wire

>>> design/bgsp_front.sv
// Front part: takes request items and classifies them before they are queued.
// Depends on bgsp_pkg for the request and job types.
`default_nettype none

module bgsp_front #(
    parameter int GRID_SIDE = 8
) (
    input  wire                 req_valid,
    output logic                req_stall,
    input  bgsp_pkg::req_t      req,
    output logic                q_push,
    output bgsp_pkg::job_t      q_job,
    input  wire                 q_full
);

    localparam logic [bgsp_pkg::MAP_W-1:0] GRID_MASK = bgsp_pkg::grid_cells(GRID_SIDE);

    logic target_ok;

    // Items are taken whenever the queue has room.
    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    assign target_ok = GRID_MASK[req.target_cell] && !req.obstacle_map[req.target_cell];

    always_comb
    begin
        q_job.obstacle_map = req.obstacle_map;
        q_job.source_cell  = req.source_cell;
        q_job.target_cell  = req.target_cell;
        // Source equal to target wins over every other check.
        if (req.source_cell == req.target_cell)
        begin
            q_job.kind = bgsp_pkg::JOB_SAME;
        end
        else if (!target_ok)
        begin
            q_job.kind = bgsp_pkg::JOB_BLOCKED;
        end
        else
        begin
            q_job.kind = bgsp_pkg::JOB_SEARCH;
        end
    end

endmodule

`default_nettype wire

>>> design/bgsp_queue.sv
// Two-entry queue of classified jobs between the front and back parts.
// Depends on bgsp_pkg for the job type.
`default_nettype none

module bgsp_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  bgsp_pkg::job_t  push_job,
    output logic            full,
    input  wire             pop,
    output logic            valid,
    output bgsp_pkg::job_t  head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    bgsp_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;

    assign full  = (level_reg == LVL_W'(DEPTH));
    assign valid = (level_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - LVL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/bgsp_back.sv
// Back part: wavefront expansion into the wave memory, backtrace and result register.
// Depends on bgsp_pkg for the job and response types and the grid-mask helpers.
`default_nettype none

module bgsp_back #(
    parameter int GRID_SIDE = 8,
    parameter int MAX_WAVES = 64
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             q_valid,
    input  bgsp_pkg::job_t  q_head,
    output logic            q_pop,
    output logic            rsp_valid,
    input  wire             rsp_stall,
    output bgsp_pkg::rsp_t  rsp
);

    localparam int MW = bgsp_pkg::MAP_W;
    localparam int CL = bgsp_pkg::CELL_W;
    localparam int AW = $clog2(MAX_WAVES);
    localparam int CW = $clog2(MAX_WAVES + 1);

    localparam logic [MW-1:0] GRID_MASK = bgsp_pkg::grid_cells(GRID_SIDE);
    localparam logic [MW-1:0] LEFT_COL  = bgsp_pkg::left_column(GRID_SIDE);
    localparam logic [MW-1:0] RIGHT_COL = LEFT_COL << (GRID_SIDE - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPAND,
        S_TRACE,
        S_DONE
    } state_t;

    // Four-neighbour step; the column masks stop moves that would wrap a row.
    function automatic logic [MW-1:0] nbr(input logic [MW-1:0] a);
        return (((a >> 1) & ~RIGHT_COL) | ((a << 1) & ~LEFT_COL) |
                (a << GRID_SIDE) | (a >> GRID_SIDE)) & GRID_MASK;
    endfunction

    state_t          state_reg,   state_next;
    logic [MW-1:0]   visited_reg, visited_next;
    logic [MW-1:0]   front_reg,   front_next;
    logic [CL-1:0]   target_reg,  target_next;
    logic [CW-1:0]   count_reg,   count_next;
    logic [AW-1:0]   idx_reg,     idx_next;
    logic [MW-1:0]   path_reg,    path_next;
    logic            reached_reg, reached_next;
    logic [CL-1:0]   len_reg,     len_next;
    logic            rsp_valid_reg, rsp_valid_next;
    bgsp_pkg::rsp_t  rsp_reg,     rsp_next;

    logic [MW-1:0]   wave_mem [MAX_WAVES];
    logic [MW-1:0]   rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;

    logic [MW-1:0]   nbr_front;
    logic [MW-1:0]   wave;
    logic [MW-1:0]   src_bit;
    logic [MW-1:0]   sel;
    logic [MW-1:0]   low;

    assign nbr_front = nbr(front_reg);
    assign wave      = nbr_front & ~visited_reg;
    assign src_bit   = (64'd1 << q_head.source_cell) & GRID_MASK;
    assign sel       = rd_data_reg & nbr_front;
    assign low       = sel & (~sel + 64'd1);

    // The read address is issued in the cycle before the trace step that uses the registered data.
    assign rd_addr = (state_reg == S_EXPAND) ? AW'(count_reg - CW'(2)) : (idx_reg - AW'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wave_mem[count_reg[AW-1:0]] <= wave;
        end
        rd_data_reg <= wave_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        visited_next   = visited_reg;
        front_next     = front_reg;
        target_next    = target_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        path_next      = path_reg;
        reached_next   = reached_reg;
        len_next       = len_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    target_next  = q_head.target_cell;
                    path_next    = '0;
                    reached_next = 1'b0;
                    len_next     = '0;
                    state_next   = S_DONE;
                    unique case (q_head.kind)
                        bgsp_pkg::JOB_SAME:
                        begin
                            reached_next = 1'b1;
                        end
                        bgsp_pkg::JOB_BLOCKED:
                        begin
                            reached_next = 1'b0;
                        end
                        bgsp_pkg::JOB_SEARCH:
                        begin
                            visited_next = q_head.obstacle_map | src_bit | ~GRID_MASK;
                            front_next   = src_bit;
                            count_next   = '0;
                            state_next   = S_EXPAND;
                        end
                        default:
                        begin
                            reached_next = 1'b0;
                        end
                    endcase
                end
            end

            S_EXPAND:
            begin
                if (visited_reg[target_reg])
                begin
                    reached_next = 1'b1;
                    len_next     = CL'(count_reg - CW'(1));
                    if (count_reg == CW'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = AW'(count_reg - CW'(2));
                        front_next = 64'd1 << target_reg;
                        state_next = S_TRACE;
                    end
                end
                else if (count_reg >= CW'(MAX_WAVES) || wave == '0)
                begin
                    // Store full or wavefront died out: no path.
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en        = 1'b1;
                    visited_next = visited_reg | wave;
                    front_next   = wave;
                    count_next   = count_reg + CW'(1);
                end
            end

            S_TRACE:
            begin
                path_next  = path_reg | low;
                front_next = low;
                if (idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.path_map    = path_reg;
                    rsp_next.reached     = reached_reg;
                    rsp_next.path_length = len_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            visited_reg   <= '0;
            front_reg     <= '0;
            target_reg    <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            path_reg      <= '0;
            reached_reg   <= 1'b0;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            visited_reg   <= visited_next;
            front_reg     <= front_next;
            target_reg    <= target_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            path_reg      <= path_next;
            reached_reg   <= reached_next;
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
